/* rtl/core/staging_ring_bump_allocator_macros.svh */
// Assertion macros for the staging ring bump allocator checker
`ifndef STAGING_RING_BUMP_ALLOCATOR_MACROS_SVH
`define STAGING_RING_BUMP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted
`define SRBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is asserted
`define SRBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also watches reset itself
`define SRBA_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/srba_pkg.sv */
// Package: request/response types and codes for the staging ring bump allocator
package srba_pkg;

    // Action codes
    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_TAG     = 2'd1;
    localparam logic [1:0] ACT_RECLAIM = 2'd2;

    // Field widths
    localparam int unsigned SIZE_W  = 32;
    localparam int unsigned ALIGN_W = 4;
    localparam int unsigned TL_W    = 64;
    localparam int unsigned OFS_W   = 32;
    localparam int unsigned BIDX_W  = 2;
    localparam int unsigned MASK_W  = 4;

    // Capacity after reset
    localparam logic [OFS_W-1:0] CAPACITY_RESET = 32'd65536;

    typedef struct packed {
        logic [1:0]         action;
        logic [SIZE_W-1:0]  request_size;
        logic [ALIGN_W-1:0] align_log2;
        logic [TL_W-1:0]    timeline;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic [BIDX_W-1:0]  buffer_index;
        logic [OFS_W-1:0]   start_offset;
        logic [MASK_W-1:0]  busy_mask;
    } t_rsp;

endpackage

/* rtl/core/srba_ring.sv */
// Buffer ring state and the single-pass allocate / tag / reclaim logic
module srba_ring #(
    parameter int unsigned BUFFER_COUNT = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  srba_pkg::t_req               i_req,
    input  logic [srba_pkg::OFS_W-1:0]   i_capacity,
    output srba_pkg::t_rsp               o_rsp
);

    localparam int unsigned IDX_W = $clog2(BUFFER_COUNT);
    localparam int unsigned OW    = srba_pkg::OFS_W;
    localparam int unsigned TW    = srba_pkg::TL_W;

    logic [OW-1:0]           r_fill [BUFFER_COUNT];
    logic [TW-1:0]           r_tag  [BUFFER_COUNT];
    logic [BUFFER_COUNT-1:0] r_busy;
    logic [IDX_W-1:0]        r_act;

    logic [OW-1:0]           n_fill [BUFFER_COUNT];
    logic [TW-1:0]           n_tag  [BUFFER_COUNT];
    logic [BUFFER_COUNT-1:0] n_busy;
    logic [IDX_W-1:0]        n_act;

    logic [OW-1:0]           align_mask;
    logic [OW:0]             aligned;
    logic [OW+1:0]           fit_sum;
    logic                    fits;
    logic [IDX_W-1:0]        act_next;
    logic                    ok;
    logic [OW-1:0]           start;
    logic [IDX_W+1:0]        idx_pad;
    logic [BUFFER_COUNT+3:0] mask_pad;

    // Alignment round-up and fit check, all sums kept wide
    always_comb begin
        align_mask = (OW'(1) << i_req.align_log2) - OW'(1);
        aligned    = ({1'b0, r_fill[r_act]} + {1'b0, align_mask}) & ~{1'b0, align_mask};
        fit_sum    = {1'b0, aligned} + {2'b00, i_req.request_size};
        fits       = (fit_sum <= {2'b00, i_capacity});
        act_next   = (r_act == IDX_W'(BUFFER_COUNT - 1)) ? '0 : r_act + IDX_W'(1);
    end

    // Next state and result fields
    always_comb begin
        n_fill = r_fill;
        n_tag  = r_tag;
        n_busy = r_busy;
        n_act  = r_act;
        ok     = 1'b0;
        start  = '0;
        case (i_req.action)
            srba_pkg::ACT_ALLOC: begin
                if (fits) begin
                    ok            = 1'b1;
                    start         = aligned[OW-1:0];
                    n_fill[r_act] = fit_sum[OW-1:0];
                end
            end
            srba_pkg::ACT_TAG: begin
                ok            = 1'b1;
                n_tag[r_act]  = i_req.timeline;
                n_busy[r_act] = 1'b1;
                n_act         = act_next;
            end
            srba_pkg::ACT_RECLAIM: begin
                ok = 1'b1;
                // every buffer compared in parallel
                for (int i = 0; i < BUFFER_COUNT; i++) begin
                    if (r_busy[i] && (i_req.timeline >= r_tag[i])) begin
                        n_fill[i] = '0;
                        n_busy[i] = 1'b0;
                    end
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // Response, index and mask trimmed to their field widths
    always_comb begin
        idx_pad            = {2'b00, n_act};
        mask_pad           = {4'b0000, n_busy};
        o_rsp.ok           = ok;
        o_rsp.buffer_index = idx_pad[srba_pkg::BIDX_W-1:0];
        o_rsp.start_offset = start;
        o_rsp.busy_mask    = mask_pad[srba_pkg::MASK_W-1:0];
    end

    // State update on each processed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUFFER_COUNT; i++) begin
                r_fill[i] <= '0;
                r_tag[i]  <= '0;
            end
            r_busy <= '0;
            r_act  <= '0;
        end else if (i_fire) begin
            r_fill <= n_fill;
            r_tag  <= n_tag;
            r_busy <= n_busy;
            r_act  <= n_act;
        end
    end

endmodule

/* rtl/core/srba_out_reg.sv */
// Result register: holds a response while the receiver stalls
module srba_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  srba_pkg::t_rsp i_rsp,
    input  logic           i_stall,
    output logic           o_can_load,
    output logic           o_valid,
    output srba_pkg::t_rsp o_rsp
);

    logic           r_valid;
    srba_pkg::t_rsp r_rsp;

    // Free when empty or when the held response leaves this cycle
    assign o_can_load = !r_valid || !i_stall;
    assign o_valid    = r_valid;
    assign o_rsp      = r_rsp;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_rsp <= i_rsp;
        end
    end

endmodule

/* rtl/core/staging_ring_bump_allocator.sv */
// Top level of the staging ring bump allocator
//
// Request channel: i_in_valid / i_in_req, stalled by o_in_stall. A request is
// taken at a rising edge with i_in_valid high and o_in_stall low.
// Response channel: o_out_valid / o_out_rsp, stalled by i_out_stall. One
// response is produced for every request, in request order.
// Configuration: i_cfg_we writes i_cfg_wdata to the capacity register at the
// clock edge; write it only while no request is outstanding.
// Path: a request is held in the request register, then the ring logic feeds
// the response register, which drives o_out_valid.
// Throughput: one request per cycle unless stalled; the ring state is updated
// as a request moves into the response register, so the next sees it at once.
// Reset (synchronous, i_rst_n low): all buffers empty and idle, buffer 0
// active, capacity 65536, both registers empty.
// Receiver stall: the response is held; the request register then holds too
// and o_in_stall rises while it is full.
module staging_ring_bump_allocator #(
    parameter int unsigned BUFFER_COUNT = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  srba_pkg::t_req             i_in_req,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output srba_pkg::t_rsp             o_out_rsp,
    input  logic                       i_out_stall,
    input  logic                       i_cfg_we,
    input  logic [srba_pkg::OFS_W-1:0] i_cfg_wdata
);

    logic                       r_in_valid;
    srba_pkg::t_req             r_in_req;
    logic [srba_pkg::OFS_W-1:0] r_capacity;
    logic                       out_can_load;
    logic                       fire;
    srba_pkg::t_rsp             ring_rsp;

    assign fire       = r_in_valid && out_can_load;
    assign o_in_stall = r_in_valid && !out_can_load;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= srba_pkg::CAPACITY_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // Request register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Request register payload
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_req <= i_in_req;
        end
    end

    srba_ring #(
        .BUFFER_COUNT (BUFFER_COUNT)
    ) u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_req      (r_in_req),
        .i_capacity (r_capacity),
        .o_rsp      (ring_rsp)
    );

    srba_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (r_in_valid),
        .i_rsp      (ring_rsp),
        .i_stall    (i_out_stall),
        .o_can_load (out_can_load),
        .o_valid    (o_out_valid),
        .o_rsp      (o_out_rsp)
    );

endmodule

/* rtl/core/srba_checker.sv */
// Port-level checker for the staging ring bump allocator, with its bind
`include "staging_ring_bump_allocator_macros.svh"

module srba_checker #(
    parameter int unsigned BUFFER_COUNT = 4
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input srba_pkg::t_rsp             o_out_rsp,
    input logic                       i_out_stall
);

    localparam logic [srba_pkg::MASK_W-1:0] BUSY_LEGAL =
        (BUFFER_COUNT >= srba_pkg::MASK_W) ? '1
        : srba_pkg::MASK_W'((1 << BUFFER_COUNT) - 1);

    // Reset empties the response register
    `SRBA_ASSERT_NEXT_RST(a_rst_empty, !i_rst_n, !o_out_valid, "response valid after reset")

    // A stalled response holds
    `SRBA_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_rsp), "stalled response changed")

    // The request side only stalls behind a stalled response
    `SRBA_ASSERT_NOW(a_in_stall_cause, o_in_stall,
        o_out_valid && i_out_stall, "request stall without response stall")

    // In-flight marks only for buffers that exist
    `SRBA_ASSERT_NOW(a_busy_range, o_out_valid,
        (o_out_rsp.busy_mask & ~BUSY_LEGAL) == '0, "busy mark beyond ring")

endmodule

bind staging_ring_bump_allocator srba_checker #(
    .BUFFER_COUNT (BUFFER_COUNT)
) u_srba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_rsp   (o_out_rsp),
    .i_out_stall (i_out_stall)
);

/* tb/sv/tb.sv */
// Self-checking testbench for the staging ring bump allocator, random stimulus and stalls
module tb;

    // Ring geometry and run pacing
    localparam int unsigned RING       = 4;
    localparam int unsigned PHASES     = 8;
    localparam int unsigned PHASE_LEN  = 210;
    localparam int unsigned CALM_TAIL  = 150;
    localparam int unsigned SETTLE     = 3;
    localparam int unsigned DRAIN      = 10;
    localparam int unsigned STALL_MAX  = 500;

    // Action code the block leaves unused
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // One entry of the stimulus queue: a request or a capacity write
    typedef struct {
        bit                         is_cap_write;
        logic [srba_pkg::OFS_W-1:0] cap;
        srba_pkg::t_req             req;
    } t_step;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    srba_pkg::t_req             i_in_req    = '0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    srba_pkg::t_rsp             o_out_rsp;
    logic                       i_out_stall = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [srba_pkg::OFS_W-1:0] i_cfg_wdata = '0;

    // Stimulus and expected responses
    t_step          step_q[$];
    srba_pkg::t_rsp rsp_q[$];
    int unsigned    req_total = 0;
    int unsigned    req_taken = 0;
    int unsigned    err_count = 0;
    logic           calm      = 1'b0;

    // Ring state as the testbench sees it
    logic [srba_pkg::OFS_W-1:0] cap_model;
    logic [srba_pkg::OFS_W-1:0] fill_ofs [RING];
    logic [srba_pkg::TL_W-1:0]  fence    [RING];
    logic                       busy_mark[RING];
    logic [1:0]                 cur_buf;

    int unsigned gap_left;
    int unsigned quiet_cycles;
    int unsigned hold_left;
    int unsigned idle_cycles;

    staging_ring_bump_allocator #(
        .BUFFER_COUNT(RING)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Apply one request to the ring state and return the response it should give
    function automatic srba_pkg::t_rsp ring_step(srba_pkg::t_req r);
        srba_pkg::t_rsp res;
        logic [63:0]    mask;
        logic [63:0]    aligned;
        logic [1:0]     slot;
        slot = cur_buf;
        res = '0;
        res.buffer_index = slot;
        case (r.action)
            srba_pkg::ACT_ALLOC: begin
                // rounding and fit test are done 64 bits wide so nothing wraps
                mask    = (64'd1 << r.align_log2) - 64'd1;
                aligned = ({32'd0, fill_ofs[slot]} + mask) & ~mask;
                if (aligned + {32'd0, r.request_size} <= {32'd0, cap_model}) begin
                    res.ok           = 1'b1;
                    res.start_offset = aligned[31:0];
                    fill_ofs[slot]   = aligned[31:0] + r.request_size;
                end
            end
            srba_pkg::ACT_TAG: begin
                fence[slot]      = r.timeline;
                busy_mark[slot]  = 1'b1;
                cur_buf          = (slot == RING - 1) ? 2'd0 : slot + 2'd1;
                res.ok           = 1'b1;
                res.buffer_index = cur_buf;
            end
            srba_pkg::ACT_RECLAIM: begin
                for (int i = 0; i < RING; i++) begin
                    if (busy_mark[i] && r.timeline >= fence[i]) begin
                        fill_ofs[i]  = '0;
                        busy_mark[i] = 1'b0;
                    end
                end
                res.ok = 1'b1;
            end
            default: begin
            end
        endcase
        for (int i = 0; i < RING; i++) res.busy_mask[i] = busy_mark[i];
        return res;
    endfunction

    task automatic push_req(logic [1:0] act, logic [srba_pkg::SIZE_W-1:0] size,
                            logic [srba_pkg::ALIGN_W-1:0] alog,
                            logic [srba_pkg::TL_W-1:0] tl);
        t_step s;
        s.is_cap_write      = 1'b0;
        s.cap               = '0;
        s.req.action        = act;
        s.req.request_size  = size;
        s.req.align_log2    = alog;
        s.req.timeline      = tl;
        step_q.push_back(s);
        req_total++;
    endtask

    task automatic push_cap(logic [srba_pkg::OFS_W-1:0] value);
        t_step s;
        s.is_cap_write = 1'b1;
        s.cap          = value;
        s.req          = '0;
        step_q.push_back(s);
    endtask

    // Stimulus, reset and end of run
    initial begin
        logic [srba_pkg::OFS_W-1:0]   phase_cap;
        logic [srba_pkg::TL_W-1:0]    tl_next;
        logic [srba_pkg::SIZE_W-1:0]  size;
        logic [srba_pkg::ALIGN_W-1:0] alog;
        int unsigned                  r;

        // directed: fill buffer 0 to the brim at reset capacity
        push_req(srba_pkg::ACT_ALLOC, 32'd0, 4'd0, 64'd0);
        push_req(srba_pkg::ACT_ALLOC, 32'd100, 4'd0, 64'd0);
        push_req(srba_pkg::ACT_ALLOC, 32'd1, 4'd15, 64'd0);
        push_req(srba_pkg::ACT_ALLOC, 32'd32767, 4'd0, 64'd0);
        push_req(srba_pkg::ACT_ALLOC, 32'd1, 4'd0, 64'd0);
        push_req(srba_pkg::ACT_ALLOC, 32'd0, 4'd0, 64'd0);
        push_req(srba_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 4'd15, 64'd0);
        push_req(ACT_UNUSED, 32'hFFFF_FFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        // directed: tag round the ring, partial and full reclaim
        push_req(srba_pkg::ACT_TAG, 32'd0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        push_req(srba_pkg::ACT_ALLOC, 32'd16, 4'd4, 64'd0);
        push_req(srba_pkg::ACT_TAG, 32'd0, 4'd0, 64'd0);
        push_req(srba_pkg::ACT_RECLAIM, 32'd0, 4'd0, 64'd0);
        push_req(srba_pkg::ACT_TAG, 32'd0, 4'd0, 64'd5);
        push_req(srba_pkg::ACT_TAG, 32'd0, 4'd0, 64'd10);
        push_req(srba_pkg::ACT_RECLAIM, 32'd0, 4'd0, 64'd7);
        push_req(srba_pkg::ACT_ALLOC, 32'd0, 4'd0, 64'd0);
        push_req(srba_pkg::ACT_RECLAIM, 32'd0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        // directed: zero capacity
        push_cap(32'd0);
        push_req(srba_pkg::ACT_ALLOC, 32'd0, 4'd0, 64'd0);
        push_req(srba_pkg::ACT_ALLOC, 32'd1, 4'd0, 64'd0);
        // directed: full capacity, rounding past 2^32
        push_cap(32'hFFFF_FFFF);
        push_req(srba_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 4'd0, 64'd0);
        push_req(srba_pkg::ACT_ALLOC, 32'd0, 4'd15, 64'd0);
        // directed: capacity lowered below the fill offset
        push_cap(32'd100);
        push_req(srba_pkg::ACT_ALLOC, 32'd0, 4'd0, 64'd0);
        push_req(srba_pkg::ACT_RECLAIM, 32'd0, 4'd0, 64'd0);
        push_req(srba_pkg::ACT_TAG, 32'd0, 4'd0, 64'd1);
        push_req(srba_pkg::ACT_RECLAIM, 32'd0, 4'd0, 64'd1);

        // random phases, each at its own capacity
        tl_next = 64'd100;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       phase_cap = 32'd0;
                1:       phase_cap = 32'd64;
                2:       phase_cap = 32'd4096;
                3:       phase_cap = srba_pkg::CAPACITY_RESET;
                4:       phase_cap = 32'h0010_0000;
                5:       phase_cap = 32'hFFFF_FFFF;
                6:       phase_cap = $urandom_range(1, 32'h0004_0000);
                default: phase_cap = 32'd300;
            endcase
            if (p == 5) tl_next = 64'hFFFF_FFFF_FFFF_FF00;
            push_cap(phase_cap);
            for (int k = 0; k < PHASE_LEN; k++) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    // allocation sized mostly against the current capacity
                    r = $urandom_range(0, 99);
                    if (r < 70)      size = (phase_cap == 0) ? 32'd0
                                          : $urandom_range(0, phase_cap / 3);
                    else if (r < 85) size = $urandom_range(0, 64);
                    else             size = $urandom;
                    alog = ($urandom_range(0, 99) < 70)
                         ? srba_pkg::ALIGN_W'($urandom_range(0, 6))
                         : srba_pkg::ALIGN_W'($urandom_range(0, 15));
                    push_req(srba_pkg::ACT_ALLOC, size, alog, {$urandom, $urandom});
                end else if (r < 78) begin
                    tl_next = tl_next + 64'($urandom_range(1, 8));
                    push_req(srba_pkg::ACT_TAG, $urandom,
                             srba_pkg::ALIGN_W'($urandom_range(0, 15)), tl_next);
                end else if (r < 96) begin
                    push_req(srba_pkg::ACT_RECLAIM, $urandom,
                             srba_pkg::ALIGN_W'($urandom_range(0, 15)),
                             tl_next - 64'($urandom_range(0, 24)));
                end else begin
                    // noise: any code, any field
                    push_req(2'($urandom_range(0, 3)), $urandom,
                             srba_pkg::ALIGN_W'($urandom_range(0, 15)),
                             {$urandom, $urandom});
                end
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_taken != req_total || rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Driver: issues requests and capacity writes from the stimulus queue
    always @(posedge i_clk) begin
        t_step head;
        if (!i_rst_n) begin
            i_in_valid   <= 1'b0;
            i_cfg_we     <= 1'b0;
            gap_left     = 0;
            quiet_cycles = 0;
            cap_model    = srba_pkg::CAPACITY_RESET;
            cur_buf      = '0;
            for (int i = 0; i < RING; i++) begin
                fill_ofs[i]  = '0;
                fence[i]     = '0;
                busy_mark[i] = 1'b0;
            end
        end else begin
            if (i_in_valid && !o_in_stall) begin
                rsp_q.push_back(ring_step(i_in_req));
                req_taken++;
            end
            // count cycles with nothing in flight before touching the register
            if (rsp_q.size() == 0 && !i_in_valid) quiet_cycles++;
            else quiet_cycles = 0;

            if (i_in_valid && o_in_stall) begin
                i_cfg_we <= 1'b0;
            end else if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
                i_cfg_we   <= 1'b0;
            end else if (step_q.size() == 0) begin
                i_in_valid <= 1'b0;
                i_cfg_we   <= 1'b0;
            end else if (step_q[0].is_cap_write) begin
                i_in_valid <= 1'b0;
                if (quiet_cycles >= SETTLE) begin
                    head = step_q.pop_front();
                    i_cfg_we     <= 1'b1;
                    i_cfg_wdata  <= head.cap;
                    cap_model    = head.cap;
                    quiet_cycles = 0;
                end else begin
                    i_cfg_we <= 1'b0;
                end
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                gap_left   = $urandom_range(1, 10) - 1;
                i_in_valid <= 1'b0;
                i_cfg_we   <= 1'b0;
            end else begin
                head = step_q.pop_front();
                i_in_valid <= 1'b1;
                i_in_req   <= head.req;
                i_cfg_we   <= 1'b0;
            end
            calm <= (step_q.size() < CALM_TAIL);
        end
    end

    // Monitor: checks each response against the oldest expectation, stalls at random
    always @(posedge i_clk) begin
        srba_pkg::t_rsp want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (rsp_q.size() == 0) begin
                    $error("response with none expected: %p", o_out_rsp);
                    err_count++;
                end else begin
                    want = rsp_q.pop_front();
                    if (o_out_rsp.ok !== want.ok) begin
                        $error("ok: expected %0h, got %0h", want.ok, o_out_rsp.ok);
                        err_count++;
                    end
                    if (o_out_rsp.buffer_index !== want.buffer_index) begin
                        $error("buffer_index: expected %0h, got %0h",
                               want.buffer_index, o_out_rsp.buffer_index);
                        err_count++;
                    end
                    if (o_out_rsp.start_offset !== want.start_offset) begin
                        $error("start_offset: expected %0h, got %0h",
                               want.start_offset, o_out_rsp.start_offset);
                        err_count++;
                    end
                    if (o_out_rsp.busy_mask !== want.busy_mask) begin
                        $error("busy_mask: expected %0h, got %0h",
                               want.busy_mask, o_out_rsp.busy_mask);
                        err_count++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold_left   = $urandom_range(1, 10) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: too long without a request or response moving
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_MAX) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
